// ----- rtl/wli_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package wli_pkg;
	localparam int unsigned MaxSegmentSteps = 63;
	localparam int unsigned StepW = 6;
	localparam int unsigned RootW = 33;
	localparam int unsigned SqW = 66;

	typedef logic [StepW-1:0] steps_t;

	typedef enum logic [0:0] {
		REG_STEP_SIZE   = 1'b0,
		REG_TOTAL_LIMIT = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [15:0] heading;
		logic [15:0]        tag;
		logic               path_start;
	} wp_t;

	typedef struct packed {
		logic signed [31:0] out_x;
		logic signed [31:0] out_y;
		logic signed [15:0] out_heading;
		logic [15:0]        out_tag;
		logic               steps_clipped;
		logic               final_point;
	} pt_t;

	// Request to the shared serial unit
	typedef struct packed {
		logic        start;
		logic        is_sqrt;
		logic [65:0] num;
		logic [32:0] den;
	} alu_req_t;

	typedef struct packed {
		logic        done;
		logic [65:0] quo;
	} alu_rsp_t;
endpackage
`default_nettype wire

// ----- rtl/wli_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
interface wp_chan_if;
	logic         valid;
	logic         ready;
	wli_pkg::wp_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface pt_chan_if;
	logic         valid;
	logic         ready;
	wli_pkg::pt_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface cfg_chan_if;
	logic        valid;
	logic        ready;
	logic [0:0]  index;
	logic [31:0] wdata;
	modport source (output valid, output index, output wdata, input ready);
	modport sink (input valid, input index, input wdata, output ready);
endinterface
`default_nettype wire

// ----- rtl/wli_serial_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Shared bit-serial unit: restoring integer square root (one result bit per
// cycle) or unsigned restoring division of a 66-bit numerator by a 33-bit
// divisor (one quotient bit per cycle).
module wli_serial_unit (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire wli_pkg::alu_req_t req,
	output wli_pkg::alu_rsp_t      rsp
);
	logic        busy_q;
	logic        done_q;
	logic        sqrt_q;
	logic [6:0]  cnt_q;
	logic [65:0] num_q;
	logic [65:0] res_q;
	logic [67:0] rem_q;
	logic [32:0] den_q;

	logic [67:0] rem_sh;
	logic [67:0] trial;
	logic        take;

	// one iteration step
	always_comb begin
		if (sqrt_q) begin
			rem_sh = {rem_q[65:0], num_q[65:64]};
			trial  = {res_q[65:0], 2'b01};
		end else begin
			rem_sh = {rem_q[66:0], num_q[65]};
			trial  = {35'd0, den_q};
		end
		take = rem_sh >= trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				sqrt_q <= req.is_sqrt;
				num_q  <= req.num;
				den_q  <= req.den;
				res_q  <= '0;
				rem_q  <= '0;
				cnt_q  <= req.is_sqrt ? 7'd33 : 7'd66;
			end else if (busy_q) begin
				rem_q <= take ? rem_sh - trial : rem_sh;
				res_q <= {res_q[64:0], take};
				num_q <= sqrt_q ? {num_q[63:0], 2'b00} : {num_q[64:0], 1'b0};
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign rsp = '{done: done_q, quo: res_q};
endmodule
`default_nettype wire

// ----- rtl/waypoint_linear_interpolator.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Channel   Dir  Beat
// wp_in     in   pos_x, pos_y, heading, tag, path_start
// pt_out    out  out_x, out_y, out_heading, out_tag, steps_clipped, final_point
// cfg       in   index (0 step_size, 1 total_limit), wdata
// Segment: squaring, square root, step count, one division per increment (x3),
// setup; then points are offered one per cycle unless the output stalls. Waypoints
// that are only stored skip all arithmetic; a zero-step one ends after the count.
// arst_n clears state; registers reset to step_size 65536, total_limit 0.
// wp_in is not ready while a segment is worked or emitted; a last point still
// waiting in the output register does not hold it off.
module waypoint_linear_interpolator (
	input  wire logic clk,
	input  wire logic arst_n,
	wp_chan_if.sink   wp_in,
	pt_chan_if.source pt_out,
	cfg_chan_if.sink  cfg
);
	typedef enum logic [3:0] {
		ST_IDLE, ST_SQX, ST_SQY, ST_ROOT, ST_QDIV, ST_DX, ST_DY, ST_DH, ST_PREP,
		ST_EMIT
	} state_t;

	state_t state_q;
	logic [30:0] step_size_q;
	logic [15:0] total_limit_q;
	logic signed [31:0] prev_x_q, prev_y_q, cur_x_q, cur_y_q;
	logic signed [15:0] prev_h_q, cur_h_q;
	logic [15:0] prev_tag_q, cur_tag_q, count_q;
	logic have_prev_q, halted_q, clipped_q;
	logic signed [32:0] dx_q, dy_q;
	logic signed [16:0] dh_q;
	logic [65:0] acc_q;
	wli_pkg::steps_t steps_q;
	logic div_run_q;
	logic [5:0] v_q;
	logic signed [32:0] ix_q, iy_q, px_q, py_q;
	logic signed [16:0] ih_q, ph_q;
	logic [32:0] mag_a;
	logic        neg_a;
	logic [32:0] dmag;

	wli_pkg::alu_req_t req;
	wli_pkg::alu_rsp_t rsp;

	wli_serial_unit u_alu (.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp));

	assign cfg.ready = 1'b1;
	assign wp_in.ready = (state_q == ST_IDLE);

	// magnitude and sign of the delta being divided
	always_comb begin
		neg_a = 1'b0;
		unique case (state_q)
			ST_DX:   begin mag_a = dx_q[32] ? 33'(-dx_q) : 33'(dx_q); neg_a = dx_q[32]; end
			ST_DY:   begin mag_a = dy_q[32] ? 33'(-dy_q) : 33'(dy_q); neg_a = dy_q[32]; end
			ST_DH:   begin
				mag_a = dh_q[16] ? 33'(17'(-dh_q)) : 33'(dh_q[16:0]);
				neg_a = dh_q[16];
			end
			default: mag_a = '0;
		endcase
		dmag = dx_q[32] ? 33'(-dx_q) : 33'(dx_q);
	end

	logic [65:0] sq_q;
	logic [5:0]  bit_q;
	logic [32:0] sq_src;
	logic [65:0] sq_nxt;
	assign sq_src = (state_q == ST_SQX) ? dmag : (dy_q[32] ? 33'(-dy_q) : 33'(dy_q));
	// shift-add partial product for the current multiplier bit
	assign sq_nxt = sq_src[bit_q] ? sq_q + (66'(sq_src) << bit_q) : sq_q;

	logic hit_limit;
	logic [15:0] cnt_next;
	assign cnt_next = (count_q != 16'hFFFF) ? count_q + 16'd1 : count_q;
	assign hit_limit = (total_limit_q != '0) && (cnt_next >= total_limit_q - 16'd1);

	logic emit_fire;
	assign emit_fire = (state_q == ST_EMIT) && (!pt_out.valid || pt_out.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			step_size_q   <= 31'd65536;
			total_limit_q <= '0;
			prev_x_q <= '0; prev_y_q <= '0; prev_h_q <= '0; prev_tag_q <= '0;
			have_prev_q <= 1'b0; halted_q <= 1'b0; count_q <= '0;
			pt_out.valid <= 1'b0;
			req.start <= 1'b0;
			div_run_q <= 1'b0;
		end else begin
			req.start <= 1'b0;
			if (cfg.valid) begin
				if (cfg.index == wli_pkg::REG_STEP_SIZE) step_size_q <= cfg.wdata[30:0];
				else total_limit_q <= cfg.wdata[15:0];
			end
			if (emit_fire) pt_out.valid <= 1'b1;
			else if (pt_out.valid && pt_out.ready) pt_out.valid <= 1'b0;
			unique case (state_q)
				ST_IDLE: if (wp_in.valid && wp_in.ready) begin
					cur_x_q <= wp_in.data.pos_x; cur_y_q <= wp_in.data.pos_y;
					cur_h_q <= wp_in.data.heading; cur_tag_q <= wp_in.data.tag;
					dx_q <= 33'(wp_in.data.pos_x) - 33'(prev_x_q);
					dy_q <= 33'(wp_in.data.pos_y) - 33'(prev_y_q);
					dh_q <= 17'(wp_in.data.heading) - 17'(prev_h_q);
					if (wp_in.data.path_start || (!halted_q && !have_prev_q)) begin
						if (wp_in.data.path_start) begin
							count_q <= '0; halted_q <= 1'b0;
						end
						prev_x_q <= wp_in.data.pos_x; prev_y_q <= wp_in.data.pos_y;
						prev_h_q <= wp_in.data.heading; prev_tag_q <= wp_in.data.tag;
						have_prev_q <= 1'b1;
					end else if (!halted_q) begin
						state_q <= ST_SQX; sq_q <= '0; bit_q <= '0; acc_q <= '0;
					end
				end
				// shift-add squaring, one multiplier bit per cycle
				ST_SQX, ST_SQY: begin
					if (bit_q == 6'd32) begin
						bit_q <= '0;
						sq_q <= '0;
						acc_q <= acc_q + sq_nxt;
						if (state_q == ST_SQX) state_q <= ST_SQY;
						else begin
							state_q <= ST_ROOT; req.start <= 1'b1; req.is_sqrt <= 1'b1;
							req.num <= acc_q + sq_nxt;
							req.den <= '0;
						end
					end else begin
						sq_q <= sq_nxt;
						bit_q <= bit_q + 6'd1;
					end
				end
				ST_ROOT: if (rsp.done) begin
					state_q <= ST_QDIV; req.start <= 1'b1; req.is_sqrt <= 1'b0;
					req.num <= 66'(rsp.quo[32:0]);
					req.den <= (step_size_q == '0) ? 33'd1 : 33'(step_size_q);
				end
				ST_QDIV: if (rsp.done) begin
					if (rsp.quo == '0) begin
						halted_q <= 1'b1;
						prev_x_q <= cur_x_q; prev_y_q <= cur_y_q;
						prev_h_q <= cur_h_q; prev_tag_q <= cur_tag_q;
						state_q <= ST_IDLE;
					end else begin
						clipped_q <= rsp.quo > 66'(wli_pkg::MaxSegmentSteps);
						steps_q <= (rsp.quo > 66'(wli_pkg::MaxSegmentSteps)) ?
							wli_pkg::steps_t'(wli_pkg::MaxSegmentSteps) :
							rsp.quo[wli_pkg::StepW-1:0];
						state_q <= ST_DX;
					end
				end
				ST_DX, ST_DY, ST_DH: if (!req.start) begin
					if (!div_run_q) begin
						req.start <= 1'b1; req.is_sqrt <= 1'b0;
						req.num <= 66'(mag_a); req.den <= 33'(steps_q);
						div_run_q <= 1'b1;
					end else if (rsp.done) begin
						div_run_q <= 1'b0;
						if (state_q == ST_DX) begin
							ix_q <= neg_a ? -33'(rsp.quo[32:0]) : 33'(rsp.quo[32:0]);
							state_q <= ST_DY;
						end else if (state_q == ST_DY) begin
							iy_q <= neg_a ? -33'(rsp.quo[32:0]) : 33'(rsp.quo[32:0]);
							state_q <= ST_DH;
						end else begin
							ih_q <= neg_a ? -17'(rsp.quo[16:0]) : 17'(rsp.quo[16:0]);
							state_q <= ST_PREP;
						end
					end
				end
				ST_PREP: begin
					px_q <= 33'(prev_x_q); py_q <= 33'(prev_y_q); ph_q <= 17'(prev_h_q);
					v_q <= '0; state_q <= ST_EMIT;
				end
				ST_EMIT: if (emit_fire) begin
					pt_out.data.out_x <= px_q[31:0];
					pt_out.data.out_y <= py_q[31:0];
					pt_out.data.out_heading <= ph_q[15:0];
					pt_out.data.out_tag <= prev_tag_q;
					pt_out.data.steps_clipped <= clipped_q;
					pt_out.data.final_point <= hit_limit || (v_q == steps_q);
					count_q <= cnt_next;
					px_q <= px_q + ix_q; py_q <= py_q + iy_q; ph_q <= ph_q + ih_q;
					v_q <= v_q + 6'd1;
					if (hit_limit) halted_q <= 1'b1;
					if (hit_limit || v_q == steps_q) begin
						prev_x_q <= cur_x_q; prev_y_q <= cur_y_q;
						prev_h_q <= cur_h_q; prev_tag_q <= cur_tag_q;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

// ----- tb/waypoint_linear_interpolator_tb.sv -----
`timescale 1ns / 1ps
module waypoint_linear_interpolator_tb;
	localparam int unsigned HalfPeriod = 10;
	localparam int unsigned ResetCycles = 10;
	localparam int unsigned SettleCycles = 600;   // longer than one zero-step segment
	localparam int unsigned IdleLimit = 20000;
	localparam int unsigned LongHold = 400;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	wp_chan_if  wp ();
	pt_chan_if  pt ();
	cfg_chan_if cfg ();

	waypoint_linear_interpolator uut (
		.clk    (clk),
		.arst_n (arst_n),
		.wp_in  (wp),
		.pt_out (pt),
		.cfg    (cfg)
	);

	always #HalfPeriod clk = ~clk;

	// predictor copy of the block's registers and state
	logic [30:0]        m_step_size = 31'd65536;
	logic [15:0]        m_total_limit = 16'd0;
	logic signed [31:0] m_prev_x = 32'sd0, m_prev_y = 32'sd0;
	logic signed [15:0] m_prev_h = 16'sd0;
	logic [15:0]        m_prev_tag = 16'd0;
	logic               m_have_prev = 1'b0, m_halted = 1'b0;
	logic [15:0]        m_count = 16'd0;

	wli_pkg::wp_t pending_wps[$];
	wli_pkg::pt_t expected_pts[$];

	int errors = 0;
	int wps_taken = 0;
	int pts_seen = 0;
	int idle_cycles = 0;
	int hold_reqs = 0;
	int holds_done = 0;
	bit calm = 1'b0;          // no idling on either side while set
	bit wp_took = 1'b0;

	// stimulus generator position
	logic signed [31:0] gen_x = 0, gen_y = 0;

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		errors++;
		$display("MISMATCH beat %0d %s: got %h want %h", pts_seen, what, got, want);
	endtask

	function automatic logic [32:0] seg_length(input logic [65:0] sq);
		logic [67:0] res, rem, trial;
		res = '0;
		rem = '0;
		for (int i = 32; i >= 0; i--) begin
			rem = (rem << 2) | sq[2*i +: 2];
			trial = (res << 2) | 68'd1;
			if (rem >= trial) begin
				rem = rem - trial;
				res = (res << 1) | 68'd1;
			end else begin
				res = res << 1;
			end
		end
		return res[32:0];
	endfunction

	task automatic store_wp(input wli_pkg::wp_t w);
		m_prev_x = w.pos_x;
		m_prev_y = w.pos_y;
		m_prev_h = w.heading;
		m_prev_tag = w.tag;
		m_have_prev = 1'b1;
	endtask

	// expected points for one accepted waypoint
	task automatic predict_points(input wli_pkg::wp_t w);
		longint dx, dy, dh, ix, iy, ih, steps, q, dv, px, py, ph;
		logic [65:0] ax, ay, sq;
		logic [32:0] root;
		bit clipped, last;
		wli_pkg::pt_t p;
		if (w.path_start) begin
			m_count = '0;
			m_halted = 1'b0;
			store_wp(w);
			return;
		end
		if (m_halted) return;
		if (!m_have_prev) begin
			store_wp(w);
			return;
		end
		dx = longint'(w.pos_x) - longint'(m_prev_x);
		dy = longint'(w.pos_y) - longint'(m_prev_y);
		dh = longint'(w.heading) - longint'(m_prev_h);
		ax = 66'((dx < 0) ? -dx : dx);
		ay = 66'((dy < 0) ? -dy : dy);
		sq = ax * ax + ay * ay;
		root = seg_length(sq);
		dv = (m_step_size == 0) ? 1 : longint'(m_step_size);
		q = longint'(root) / dv;
		clipped = q > longint'(wli_pkg::MaxSegmentSteps);
		steps = clipped ? longint'(wli_pkg::MaxSegmentSteps) : q;
		if (steps == 0) begin
			m_halted = 1'b1;
			store_wp(w);
			return;
		end
		ix = dx / steps;
		iy = dy / steps;
		ih = dh / steps;
		for (longint v = 0; v <= steps; v++) begin
			px = longint'(m_prev_x) + ix * v;
			py = longint'(m_prev_y) + iy * v;
			ph = longint'(m_prev_h) + ih * v;
			last = (v == steps);
			p.out_x = px[31:0];
			p.out_y = py[31:0];
			p.out_heading = ph[15:0];
			p.out_tag = m_prev_tag;
			p.steps_clipped = clipped;
			if (m_count != 16'hFFFF) m_count++;
			if (m_total_limit != 0 && m_count >= m_total_limit - 16'd1) begin
				m_halted = 1'b1;
				last = 1'b1;
			end
			p.final_point = last;
			expected_pts = {expected_pts, p};
			if (m_halted) break;
		end
		store_wp(w);
	endtask

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// waypoint driver
	int wp_gap = 0;
	always @(negedge clk) begin
		if (!arst_n) begin
			wp.valid <= 1'b0;
			wp.data <= '0;
		end else begin
			if (wp.valid && !wp_took) begin
				// hold the beat until it is taken
			end else if (wp_gap > 0) begin
				wp.valid <= 1'b0;
				wp_gap--;
			end else if (pending_wps.size() > 0) begin
				wp.valid <= 1'b1;
				wp.data <= pending_wps[0];
				wp_gap = pick_gap();
			end else begin
				wp.valid <= 1'b0;
			end
		end
	end

	// point receiver backpressure
	int rd_gap = 0;
	int long_cnt = 0;
	always @(negedge clk) begin
		if (!arst_n) begin
			pt.ready <= 1'b0;
		end else begin
			if (holds_done < hold_reqs) begin
				if (long_cnt == 0) long_cnt = LongHold;
				pt.ready <= 1'b0;
				long_cnt--;
				if (long_cnt == 0) holds_done++;
			end else if (rd_gap > 0) begin
				pt.ready <= 1'b0;
				rd_gap--;
			end else begin
				pt.ready <= 1'b1;
				if ($urandom_range(0, 3) == 0) rd_gap = pick_gap();
			end
		end
	end

	// monitor, checker and watchdog
	always @(posedge clk) begin
		wli_pkg::pt_t e;
		bit any;
		if (arst_n) begin
			any = 1'b0;
			wp_took = wp.valid && wp.ready;
			if (wp_took) begin
				any = 1'b1;
				wps_taken++;
				predict_points(wp.data);
				void'(pending_wps.pop_front());
			end
			if (pt.valid && pt.ready) begin
				any = 1'b1;
				pts_seen++;
				if (expected_pts.size() == 0) begin
					report("unexpected point", pt.data.out_x, 32'h0);
				end else begin
					e = expected_pts.pop_front();
					if (pt.data.out_x !== e.out_x) report("out_x", pt.data.out_x, e.out_x);
					if (pt.data.out_y !== e.out_y) report("out_y", pt.data.out_y, e.out_y);
					if (pt.data.out_heading !== e.out_heading)
						report("out_heading", 32'(pt.data.out_heading),
							32'(e.out_heading));
					if (pt.data.out_tag !== e.out_tag)
						report("out_tag", 32'(pt.data.out_tag), 32'(e.out_tag));
					if (pt.data.steps_clipped !== e.steps_clipped)
						report("steps_clipped", 32'(pt.data.steps_clipped),
							32'(e.steps_clipped));
					if (pt.data.final_point !== e.final_point)
						report("final_point", 32'(pt.data.final_point),
							32'(e.final_point));
				end
			end
			if (cfg.valid && cfg.ready) any = 1'b1;
			idle_cycles = any ? 0 : idle_cycles + 1;
			if (idle_cycles >= IdleLimit) begin
				$display("timeout: no beat for %0d cycles", IdleLimit);
				$display("end of test: mismatches");
				$finish;
			end
		end
	end

	task automatic write_reg(input wli_pkg::reg_idx_t idx, input logic [31:0] val);
		@(negedge clk);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.wdata <= val;
		do @(posedge clk); while (!cfg.ready);
		if (idx == wli_pkg::REG_STEP_SIZE) m_step_size = val[30:0];
		else m_total_limit = val[15:0];
		@(negedge clk);
		cfg.valid <= 1'b0;
	endtask

	task automatic drain();
		while (pending_wps.size() > 0 || wp.valid || expected_pts.size() > 0)
			@(posedge clk);
		repeat (SettleCycles) @(posedge clk);
	endtask

	task automatic push_wp(input logic [31:0] x, input logic [31:0] y, input logic [15:0] h,
			input logic [15:0] t, input bit s);
		wli_pkg::wp_t w;
		w.pos_x = x;
		w.pos_y = y;
		w.heading = h;
		w.tag = t;
		w.path_start = s;
		pending_wps = {pending_wps, w};
	endtask

	// one random waypoint, mostly well-formed path steps near the last one
	task automatic push_random(input longint span);
		int r;
		longint m, ox, oy;
		r = $urandom_range(0, 99);
		if (r < 10) begin
			gen_x = $urandom;
			gen_y = $urandom;
			push_wp(gen_x, gen_y, 16'($urandom), 16'($urandom), 1'b1);
		end else if (r < 18) begin
			push_wp($urandom, $urandom, 16'($urandom), 16'($urandom),
				1'($urandom_range(0, 1)));
		end else if (r < 22) begin
			push_wp(gen_x, gen_y, 16'($urandom), 16'($urandom), 1'b0);
		end else begin
			m = span * $urandom_range(0, 80);
			ox = (longint'($urandom_range(0, 2000)) - 1000) * m / 1000;
			oy = (longint'($urandom_range(0, 2000)) - 1000) * m / 1000;
			gen_x = gen_x + ox[31:0];
			gen_y = gen_y + oy[31:0];
			push_wp(gen_x, gen_y, 16'($urandom), 16'($urandom), 1'b0);
		end
	endtask

	task automatic random_phase(input logic [31:0] stp, input logic [31:0] lim, input int n,
			input longint span);
		write_reg(wli_pkg::REG_STEP_SIZE, stp);
		write_reg(wli_pkg::REG_TOTAL_LIMIT, lim);
		push_wp(gen_x, gen_y, 16'h0, 16'h0, 1'b1);
		for (int i = 0; i < n; i++) push_random(span);
		drain();
	endtask

	initial begin
		cfg.valid = 1'b0;
		cfg.index = wli_pkg::REG_STEP_SIZE;
		cfg.wdata = '0;
		repeat (ResetCycles) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: reset values, first waypoint with no start, short segment
		calm = 1'b1;
		push_wp(32'h0, 32'h0, 16'h7FFF, 16'hFFFF, 1'b0);
		push_wp(32'h000A_0000, 32'h0, 16'h8000, 16'h0001, 1'b0);
		// extremes of position and heading, step count saturates
		push_wp(32'h8000_0000, 32'h8000_0000, 16'h8000, 16'h0000, 1'b1);
		push_wp(32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'h7FFF, 16'hFFFF, 1'b0);
		push_wp(32'h8000_0000, 32'h7FFF_FFFF, 16'h8000, 16'hA5A5, 1'b0);
		// zero-length segment halts, later input ignored, new path restarts
		push_wp(32'h8000_0000, 32'h7FFF_FFFF, 16'h1234, 16'h5A5A, 1'b0);
		push_wp(32'h0100_0000, 32'h0, 16'h0, 16'h0002, 1'b0);
		push_wp(32'hFFFF_0000, 32'h0003_0000, 16'h0100, 16'h0003, 1'b1);
		push_wp(32'h0002_0000, 32'hFFFF_0000, 16'hFF00, 16'h0004, 1'b0);
		drain();
		calm = 1'b0;

		// total limit of one and a short limit, minimum step size
		write_reg(wli_pkg::REG_TOTAL_LIMIT, 32'd1);
		push_wp(32'h0, 32'h0, 16'h0, 16'h0010, 1'b1);
		push_wp(32'h0005_0000, 32'h0, 16'h0, 16'h0011, 1'b0);
		push_wp(32'h0009_0000, 32'h0, 16'h0, 16'h0012, 1'b0);
		drain();
		write_reg(wli_pkg::REG_STEP_SIZE, 32'h8000_0001);
		write_reg(wli_pkg::REG_TOTAL_LIMIT, 32'd5);
		push_wp(32'h0, 32'h0, 16'h0, 16'h0020, 1'b1);
		push_wp(32'h0000_0003, 32'hFFFF_FFFD, 16'h0040, 16'h0021, 1'b0);
		push_wp(32'h0000_0100, 32'h0000_0100, 16'hFFC0, 16'h0022, 1'b0);
		drain();

		// random paths over several settings, with a sender pause and a long hold
		write_reg(wli_pkg::REG_STEP_SIZE, 32'd65536);
		write_reg(wli_pkg::REG_TOTAL_LIMIT, 32'd0);
		for (int i = 0; i < 35; i++) push_random(65536);
		drain();
		for (int i = 0; i < 15; i++) push_random(65536);
		hold_reqs++;
		for (int i = 0; i < 15; i++) push_random(65536);
		drain();
		random_phase(32'd4096, 32'd20, 40, 4096);
		random_phase(32'h7FFF_FFFF, 32'd65535, 30, 32'd50000000);
		random_phase(32'd1, 32'd0, 25, 1);
		random_phase(32'd300000, 32'd200, 40, 300000);
		calm = 1'b1;
		random_phase(32'd70000, 32'd0, 25, 70000);
		calm = 1'b0;
		random_phase(32'd65536, 32'd1, 20, 65536);

		$display("covered %0d waypoints and %0d points over step sizes 1 to 2^31-1,",
			wps_taken, pts_seen);
		$display("limits 0 to 65535, halts, restarts, saturation and long output stalls");
		if (errors == 0 && expected_pts.size() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end
endmodule
